// ===== hdl/bgc_pkg.sv =====
package bgc_pkg;

    // width of the time stamps held in state and of all time differences
    localparam int TIME_WIDTH = 32;

    localparam int NOW_WIDTH   = 32;
    localparam int CFG_WIDTH   = 16;
    localparam int INDEX_WIDTH = 3;

    // register indexes of the configuration port
    localparam logic [INDEX_WIDTH-1:0] REG_POLARITY   = 3'd0;
    localparam logic [INDEX_WIDTH-1:0] REG_DEBOUNCE   = 3'd1;
    localparam logic [INDEX_WIDTH-1:0] REG_CLICK      = 3'd2;
    localparam logic [INDEX_WIDTH-1:0] REG_DOUBLE_GAP = 3'd3;
    localparam logic [INDEX_WIDTH-1:0] REG_LONG       = 3'd4;
    localparam logic [INDEX_WIDTH-1:0] REG_REPEAT     = 3'd5;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_PRESS   = 3'd1,
        EV_RELEASE = 3'd2,
        EV_LONG    = 3'd3,
        EV_CLICK   = 3'd4,
        EV_DOUBLE  = 3'd5,
        EV_HOLD    = 3'd6
    } event_t;

    typedef struct packed {
        logic                 polarity_active_high;
        logic [CFG_WIDTH-1:0] debounce_time;
        logic [CFG_WIDTH-1:0] click_time;
        logic [CFG_WIDTH-1:0] double_gap_time;
        logic [CFG_WIDTH-1:0] long_time;
        logic [CFG_WIDTH-1:0] repeat_interval;
    } cfg_t;

    typedef struct packed {
        logic                  raw_seen;
        logic                  stable_level;
        logic [TIME_WIDTH-1:0] change_time;
        logic [TIME_WIDTH-1:0] press_time;
        logic [TIME_WIDTH-1:0] release_time;
        logic [TIME_WIDTH-1:0] repeat_time;
        logic [1:0]            click_count;
    } gesture_state_t;

endpackage

// ===== hdl/button_gesture_classifier.sv =====
// button gesture classifier: takes one pin sample with a free-running
// millisecond stamp per item and returns exactly one result item per input
// item (event code and the debounced pressed level). the level is flipped
// for polarity, debounced against debounce_time, and classified into press,
// release, long, click, double and hold repeat events; all time differences
// wrap modulo 2^32. an item sits in an input register, its classification
// and state update are one short subtract-compare path, and the result goes
// to an output register, so one item is accepted every cycle while the
// result side takes its items, and each result is presented from the output
// register once its item leaves the input register. configuration is a
// plain write port (index 0 polarity, 1 debounce, 2 click, 3 double gap,
// 4 long, 5 repeat interval); write it only while no item is in flight
module button_gesture_classifier (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [bgc_pkg::INDEX_WIDTH-1:0] cfg_index,
    input  logic [bgc_pkg::CFG_WIDTH-1:0]   cfg_wdata,
    // sample items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [39:0]                     s_tdata,   // pin_level, now_ms[31:0], zero pad
    // event items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata    // event_code[2:0], pressed, zero pad
);
    import bgc_pkg::*;

    cfg_t   cfg;
    event_t ev;
    logic   pressed;

    // input register
    logic                 in_valid_reg;
    logic                 in_pin_reg;
    logic [NOW_WIDTH-1:0] in_now_reg;

    // result register
    logic       out_valid_reg;
    logic [2:0] out_event_reg;
    logic       out_pressed_reg;

    // an item moves from the input register to the result register when the
    // result slot is free or its item is being taken in this cycle
    logic advance;
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    bgc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // state advances only when its item leaves the input register
    bgc_classify u_classify (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .cfg        (cfg),
        .pin_level  (in_pin_reg),
        .now_ms     (in_now_reg),
        .event_code (ev),
        .pressed    (pressed)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_pin_reg <= s_tdata[0];
            in_now_reg <= s_tdata[32:1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_event_reg   <= ev;
            out_pressed_reg <= pressed;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_pressed_reg, out_event_reg};

endmodule

// ===== hdl/bgc_cfg.sv =====
module bgc_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [bgc_pkg::INDEX_WIDTH-1:0] cfg_index,
    input  logic [bgc_pkg::CFG_WIDTH-1:0]   cfg_wdata,
    output bgc_pkg::cfg_t                   cfg
);
    import bgc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_POLARITY:   cfg_next.polarity_active_high = cfg_wdata[0];
                REG_DEBOUNCE:   cfg_next.debounce_time        = cfg_wdata;
                REG_CLICK:      cfg_next.click_time           = cfg_wdata;
                REG_DOUBLE_GAP: cfg_next.double_gap_time      = cfg_wdata;
                REG_LONG:       cfg_next.long_time            = cfg_wdata;
                REG_REPEAT:     cfg_next.repeat_interval      = cfg_wdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.polarity_active_high <= 1'b0;
            cfg_reg.debounce_time        <= CFG_WIDTH'(20);
            cfg_reg.click_time           <= CFG_WIDTH'(300);
            cfg_reg.double_gap_time      <= CFG_WIDTH'(250);
            cfg_reg.long_time            <= CFG_WIDTH'(1000);
            cfg_reg.repeat_interval      <= CFG_WIDTH'(200);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/bgc_classify.sv =====
module bgc_classify (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  bgc_pkg::cfg_t                 cfg,
    input  logic                          pin_level,
    input  logic [bgc_pkg::NOW_WIDTH-1:0] now_ms,
    output bgc_pkg::event_t               event_code,
    output logic                          pressed
);
    import bgc_pkg::*;

    gesture_state_t state_reg;
    gesture_state_t state_next;
    event_t         ev;

    always_comb begin
        logic                  raw;
        logic [TIME_WIDTH-1:0] now;
        logic [TIME_WIDTH-1:0] dur;
        logic                  count_click;

        now         = TIME_WIDTH'(now_ms);
        raw         = cfg.polarity_active_high ? pin_level : ~pin_level;
        state_next  = state_reg;
        ev          = EV_NONE;
        count_click = 1'b0;
        dur         = now - state_reg.press_time;

        if (raw != state_reg.raw_seen) begin
            state_next.raw_seen    = raw;
            state_next.change_time = now;
        end

        if ((now - state_next.change_time) >= TIME_WIDTH'(cfg.debounce_time)) begin
            if (state_reg.stable_level != state_next.raw_seen) begin
                state_next.stable_level = state_next.raw_seen;
                if (state_next.raw_seen) begin
                    state_next.press_time  = now;
                    state_next.repeat_time = now;
                    ev = EV_PRESS;
                end else begin
                    ev = EV_RELEASE;
                    if (dur < TIME_WIDTH'(cfg.click_time)) begin
                        count_click = 1'b1;
                    end else if (dur > TIME_WIDTH'(cfg.long_time)) begin
                        ev = EV_LONG;
                        state_next.click_count = 2'd0;
                    end else begin
                        count_click = 1'b1;
                    end
                end
            end else if (!state_reg.stable_level) begin
                // quiet gap after the last counted release closes the gesture
                if (state_reg.click_count != 2'd0 &&
                    (now - state_reg.release_time) >=
                        TIME_WIDTH'(cfg.double_gap_time)) begin
                    ev = (state_reg.click_count >= 2'd2) ? EV_DOUBLE : EV_CLICK;
                    state_next.click_count = 2'd0;
                end
            end else begin
                if (dur >= TIME_WIDTH'(cfg.long_time) &&
                    (now - state_reg.repeat_time) >=
                        TIME_WIDTH'(cfg.repeat_interval)) begin
                    state_next.repeat_time = now;
                    ev = EV_HOLD;
                end
            end
        end

        if (count_click) begin
            if (state_reg.click_count != 2'd3) begin
                state_next.click_count = state_reg.click_count + 2'd1;
            end
            state_next.release_time = now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (step) begin
            state_reg <= state_next;
        end
    end

    assign event_code = ev;
    assign pressed    = state_next.stable_level;

`ifndef SYNTHESIS
    a_press_sets_level: assert property (@(posedge aclk) disable iff (!aresetn)
        step && ev == EV_PRESS |=> state_reg.stable_level)
        else $error("press did not set the debounced level");

    a_hold_only_pressed: assert property (@(posedge aclk) disable iff (!aresetn)
        step && ev == EV_HOLD |=> state_reg.stable_level &&
            state_reg.repeat_time == TIME_WIDTH'($past(now_ms)))
        else $error("hold repeat without a held button or stamp");

    a_gesture_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        step && (ev == EV_CLICK || ev == EV_DOUBLE || ev == EV_LONG)
            |=> state_reg.click_count == 2'd0)
        else $error("click count not cleared after a gesture");

    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(state_reg))
        else $error("gesture state changed without an item");
`endif

endmodule

// ===== verif/tb_button_gesture_classifier.sv =====
module tb_button_gesture_classifier;

    import bgc_pkg::*;

    // result latency of the block plus some margin, used for quiet pauses
    localparam int PIPE_LAT  = 2;
    localparam int QUIET_CYC = PIPE_LAT + 2;

    // indexes past the last register, writes there must be dropped
    localparam logic [INDEX_WIDTH-1:0] REG_UNUSED_6 = 3'd6;
    localparam logic [INDEX_WIDTH-1:0] REG_UNUSED_7 = 3'd7;

    localparam logic [CFG_WIDTH-1:0] CFG_MAX = 16'hFFFF;

    // one result item: event code and debounced level
    typedef struct packed {
        event_t ev;
        logic   pressed;
    } gesture_t;

    // one row of the directed part: a register write or a sample item,
    // with an optional hand-typed result
    typedef struct packed {
        bit                   is_write;
        logic [INDEX_WIDTH-1:0] idx;
        logic [CFG_WIDTH-1:0] val;
        logic                 pin;
        logic [NOW_WIDTH-1:0] now;
        bit                   given;
        event_t               ev;
        logic                 pressed;
    } plan_row_t;

    localparam int PLAN_LEN = 32;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // dut inputs, all known from time zero
    logic                   cfg_wr_en = 1'b0;
    logic [INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_WIDTH-1:0]   cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic [39:0]            s_tdata   = '0;   // pin_level, now_ms[31:0], zero pad
    logic                   m_tready  = 1'b0;

    // dut outputs
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;                      // event_code[2:0], pressed, zero pad

    // expected results in item order
    gesture_t expected_events[$];
    gesture_t got_want;

    // bookkeeping
    int err_count = 0;
    int n_items   = 0;
    int n_writes  = 0;
    int idle_pct  = 37;
    int ev_tally [8];

    // shadow copy of the registers, at reset values
    logic                 pol_high = 1'b0;
    logic [CFG_WIDTH-1:0] deb_ms   = 16'd20;
    logic [CFG_WIDTH-1:0] tap_ms   = 16'd300;
    logic [CFG_WIDTH-1:0] gap_ms   = 16'd250;
    logic [CFG_WIDTH-1:0] long_ms  = 16'd1000;
    logic [CFG_WIDTH-1:0] rep_ms   = 16'd200;

    // shadow copy of the gesture tracking state
    logic                  raw_level     = 1'b0;
    logic                  deb_pressed   = 1'b0;
    logic [TIME_WIDTH-1:0] raw_stamp     = '0;
    logic [TIME_WIDTH-1:0] press_stamp   = '0;
    logic [TIME_WIDTH-1:0] release_stamp = '0;
    logic [TIME_WIDTH-1:0] repeat_stamp  = '0;
    logic [1:0]            clicks        = 2'd0;

    // directed part: reset settings, polarity flip, zero and full-scale thresholds
    plan_row_t plan [PLAN_LEN] = '{
        // reset settings: pin high is released
        '{1'b0, 3'd0, 16'd0, 1'b1, 32'd0,          1'b1, EV_NONE,  1'b0},
        // stamp going backwards looks like a very long time
        '{1'b0, 3'd0, 16'd0, 1'b1, 32'hFFFF_FFFF,  1'b1, EV_NONE,  1'b0},
        // press still bouncing
        '{1'b0, 3'd0, 16'd0, 1'b0, 32'd100,        1'b1, EV_NONE,  1'b0},
        '{1'b0, 3'd0, 16'd0, 1'b0, 32'd120,        1'b1, EV_PRESS, 1'b1},
        // held to the long time, first hold repeat
        '{1'b0, 3'd0, 16'd0, 1'b0, 32'd1120,       1'b0, EV_NONE,  1'b0},
        '{1'b0, 3'd0, 16'd0, 1'b1, 32'd1200,       1'b0, EV_NONE,  1'b0},
        // long release
        '{1'b0, 3'd0, 16'd0, 1'b1, 32'd1220,       1'b0, EV_NONE,  1'b0},
        // active high with a wide value, debounce off, widest double gap
        '{1'b1, REG_POLARITY,   CFG_MAX, 1'b0, 32'd0, 1'b0, EV_NONE, 1'b0},
        '{1'b1, REG_DEBOUNCE,   16'd0,   1'b0, 32'd0, 1'b0, EV_NONE, 1'b0},
        '{1'b1, REG_DOUBLE_GAP, CFG_MAX, 1'b0, 32'd0, 1'b0, EV_NONE, 1'b0},
        // writes past the last register go nowhere
        '{1'b1, REG_UNUSED_6,   16'd7,   1'b0, 32'd0, 1'b0, EV_NONE, 1'b0},
        '{1'b1, REG_UNUSED_7,   CFG_MAX, 1'b0, 32'd0, 1'b0, EV_NONE, 1'b0},
        // press taken at once
        '{1'b0, 3'd0, 16'd0, 1'b1, 32'd2000,       1'b1, EV_PRESS, 1'b1},
        // four quick clicks, counter saturates
        '{1'b0, 3'd0, 16'd0, 1'b0, 32'd2010,       1'b0, EV_NONE,  1'b0},
        '{1'b0, 3'd0, 16'd0, 1'b1, 32'd2020,       1'b0, EV_NONE,  1'b0},
        '{1'b0, 3'd0, 16'd0, 1'b0, 32'd2030,       1'b0, EV_NONE,  1'b0},
        '{1'b0, 3'd0, 16'd0, 1'b1, 32'd2040,       1'b0, EV_NONE,  1'b0},
        '{1'b0, 3'd0, 16'd0, 1'b0, 32'd2050,       1'b0, EV_NONE,  1'b0},
        '{1'b0, 3'd0, 16'd0, 1'b1, 32'd2060,       1'b0, EV_NONE,  1'b0},
        '{1'b0, 3'd0, 16'd0, 1'b0, 32'd2070,       1'b0, EV_NONE,  1'b0},
        // exactly the full gap later: double
        '{1'b0, 3'd0, 16'd0, 1'b0, 32'd67605,      1'b0, EV_NONE,  1'b0},
        // all remaining thresholds zero
        '{1'b1, REG_CLICK,      16'd0,   1'b0, 32'd0, 1'b0, EV_NONE, 1'b0},
        '{1'b1, REG_DOUBLE_GAP, 16'd0,   1'b0, 32'd0, 1'b0, EV_NONE, 1'b0},
        '{1'b1, REG_LONG,       16'd0,   1'b0, 32'd0, 1'b0, EV_NONE, 1'b0},
        '{1'b1, REG_REPEAT,     16'd0,   1'b0, 32'd0, 1'b0, EV_NONE, 1'b0},
        '{1'b0, 3'd0, 16'd0, 1'b1, 32'd70000,      1'b0, EV_NONE,  1'b0},
        // hold repeat every item, even with no time passing
        '{1'b0, 3'd0, 16'd0, 1'b1, 32'd70001,      1'b0, EV_NONE,  1'b0},
        '{1'b0, 3'd0, 16'd0, 1'b1, 32'd70001,      1'b0, EV_NONE,  1'b0},
        // any duration is long with a zero long time
        '{1'b0, 3'd0, 16'd0, 1'b0, 32'd70002,      1'b0, EV_NONE,  1'b0},
        '{1'b0, 3'd0, 16'd0, 1'b1, 32'd70003,      1'b0, EV_NONE,  1'b0},
        // zero-length press falls through to a counted release
        '{1'b0, 3'd0, 16'd0, 1'b0, 32'd70003,      1'b0, EV_NONE,  1'b0},
        // single click reported on the next quiet item
        '{1'b0, 3'd0, 16'd0, 1'b0, 32'd70004,      1'b0, EV_NONE,  1'b0}
    };

    button_gesture_classifier u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 2 time unit clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // result side stalls at random
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= idle_pct);
    end

    // wrapping time difference
    function automatic logic [TIME_WIDTH-1:0] span(input logic [TIME_WIDTH-1:0] later,
                                                   input logic [TIME_WIDTH-1:0] earlier);
        return later - earlier;
    endfunction

    // gesture predictor: advances the shadow state by one sample
    function automatic gesture_t classify(input logic pin, input logic [NOW_WIDTH-1:0] now);
        gesture_t              r;
        logic                  lvl;
        logic [TIME_WIDTH-1:0] held;
        lvl  = pol_high ? pin : ~pin;
        r.ev = EV_NONE;
        // restart the debounce window on any raw change
        if (lvl != raw_level) begin
            raw_level = lvl;
            raw_stamp = now;
        end
        if (span(now, raw_stamp) >= deb_ms) begin
            if (deb_pressed != raw_level) begin
                deb_pressed = raw_level;
                if (deb_pressed) begin
                    press_stamp  = now;
                    repeat_stamp = now;
                    r.ev         = EV_PRESS;
                end else begin
                    held = span(now, press_stamp);
                    // long only when not short enough for a click
                    if (held >= tap_ms && held > long_ms) begin
                        r.ev   = EV_LONG;
                        clicks = 2'd0;
                    end else begin
                        r.ev = EV_RELEASE;
                        if (clicks != 2'd3) clicks = clicks + 2'd1;
                        release_stamp = now;
                    end
                end
            end else if (!deb_pressed) begin
                // quiet after release: report the gathered clicks
                if (clicks != 2'd0 && span(now, release_stamp) >= gap_ms) begin
                    r.ev   = (clicks >= 2'd2) ? EV_DOUBLE : EV_CLICK;
                    clicks = 2'd0;
                end
            end else if (span(now, press_stamp) >= long_ms &&
                         span(now, repeat_stamp) >= rep_ms) begin
                repeat_stamp = now;
                r.ev         = EV_HOLD;
            end
        end
        r.pressed = deb_pressed;
        return r;
    endfunction

    // drop valid, let every result come out, then a few more cycles
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (expected_events.size() != 0) @(posedge aclk);
        repeat (QUIET_CYC) @(posedge aclk);
    endtask

    // register write while the block is idle
    task automatic set_reg(input logic [INDEX_WIDTH-1:0] idx, input logic [CFG_WIDTH-1:0] val);
        quiesce();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        n_writes++;
        case (idx)
            REG_POLARITY:   pol_high = val[0];
            REG_DEBOUNCE:   deb_ms   = val;
            REG_CLICK:      tap_ms   = val;
            REG_DOUBLE_GAP: gap_ms   = val;
            REG_LONG:       long_ms  = val;
            REG_REPEAT:     rep_ms   = val;
            default: ;
        endcase
    endtask

    // queue the expected result and hand one sample item to the block
    task automatic offer(input logic pin, input logic [NOW_WIDTH-1:0] now,
                         input bit given, input gesture_t fixed);
        gesture_t want;
        want = classify(pin, now);
        if (given) want = fixed;
        expected_events.push_back(want);
        n_items++;
        // random gaps before the item
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, now, pin};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // threshold for a random phase: mostly scaled, sometimes an extreme
    function automatic logic [CFG_WIDTH-1:0] pick_time(input int hi, input int mode);
        if (mode == 1) return '0;
        if (mode == 2) return CFG_MAX;
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CFG_MAX;
            default: return CFG_WIDTH'($urandom_range(0, (hi > 65535) ? 65535 : hi));
        endcase
    endfunction

    // random phase: mode 0 random thresholds, 1 all zero, 2 all full scale
    task automatic run_phase(input int scale, input int n, input int mode);
        logic                 level;
        logic                 pin;
        logic [NOW_WIDTH-1:0] now;
        int                   hold_left;
        set_reg(REG_POLARITY,   CFG_WIDTH'($urandom));
        set_reg(REG_DEBOUNCE,   pick_time(2 * scale, mode));
        set_reg(REG_CLICK,      pick_time(8 * scale, mode));
        set_reg(REG_DOUBLE_GAP, pick_time(8 * scale, mode));
        set_reg(REG_LONG,       pick_time(16 * scale, mode));
        set_reg(REG_REPEAT,     pick_time(4 * scale, mode));
        if ($urandom_range(0, 1) == 0)
            set_reg($urandom_range(0, 1) ? REG_UNUSED_6 : REG_UNUSED_7, CFG_WIDTH'($urandom));
        // start near the wrap point now and then
        if ($urandom_range(0, 3) == 0) now = 32'hFFFF_FFFF - $urandom_range(0, 50 * scale);
        else now = $urandom;
        level     = 1'($urandom_range(0, 1));
        hold_left = 0;
        for (int i = 0; i < n; i++) begin
            // button held or released for a run of samples, short or long
            if (hold_left == 0) begin
                level     = ~level;
                hold_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 60)
                                                       : $urandom_range(1, 10);
            end
            hold_left--;
            // time mostly creeps forward, sometimes jumps anywhere
            if ($urandom_range(0, 99) < 3) now = $urandom;
            else now = now + $urandom_range(0, scale);
            pin = pol_high ? level : ~level;
            // contact bounce
            if ($urandom_range(0, 99) < 8) pin = ~pin;
            offer(pin, now, 1'b0, '0);
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            ev_tally[m_tdata[2:0]]++;
            if (expected_events.size() == 0) begin
                $display("%0t: result with none expected, got ev=%0d pressed=%0b",
                         $time, m_tdata[2:0], m_tdata[3]);
                err_count++;
            end else begin
                got_want = expected_events.pop_front();
                if (m_tdata[2:0] != got_want.ev) begin
                    $display("%0t: event_code expected %0d got %0d",
                             $time, got_want.ev, m_tdata[2:0]);
                    err_count++;
                end
                if (m_tdata[3] != got_want.pressed) begin
                    $display("%0t: pressed expected %0b got %0b",
                             $time, got_want.pressed, m_tdata[3]);
                    err_count++;
                end
            end
        end
    end

    // run limit
    initial begin
        #400000;
        $display("[button_gesture_classifier] ERROR");
        $finish;
    end

    // main sequence
    initial begin
        for (int k = 0; k < 8; k++) ev_tally[k] = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part
        for (int k = 0; k < PLAN_LEN; k++) begin
            if (plan[k].is_write) set_reg(plan[k].idx, plan[k].val);
            else offer(plan[k].pin, plan[k].now, plan[k].given,
                       '{ev: plan[k].ev, pressed: plan[k].pressed});
        end

        // random part over several settings; phase at scale 20 runs without stalls
        run_phase(4,     80, 0);
        run_phase(1,     80, 1);
        idle_pct = 0;
        run_phase(20,    80, 0);
        idle_pct = 37;
        run_phase(300,   80, 0);
        run_phase(16384, 80, 2);
        run_phase(4,     80, 0);
        run_phase(50,    80, 0);

        // all results in, then a short pause
        quiesce();

        $display("%0d sample items checked over %0d register writes, both polarities,",
                 n_items, n_writes);
        $display("zero and full-scale thresholds: press %0d release %0d long %0d",
                 ev_tally[EV_PRESS], ev_tally[EV_RELEASE], ev_tally[EV_LONG]);
        $display("click %0d double %0d hold %0d",
                 ev_tally[EV_CLICK], ev_tally[EV_DOUBLE], ev_tally[EV_HOLD]);
        if (err_count == 0 && expected_events.size() == 0) begin
            $display("[button_gesture_classifier] OK");
        end else begin
            $display("[button_gesture_classifier] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/bgc_pkg.sv
hdl/bgc_cfg.sv
hdl/bgc_classify.sv
hdl/button_gesture_classifier.sv
verif/tb_button_gesture_classifier.sv
